// ===== sv/hsm_pkg.sv =====
package hsm_pkg;

  localparam int BEAT_W     = 64;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 8;
  localparam int STALE_W    = 16;

  // register indexes on the config channel
  localparam logic [CFG_ADDR_W-1:0] REG_CHK_PERIOD  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_STALL_LIMIT = CFG_ADDR_W'(1);

  localparam logic [CFG_DATA_W-1:0] CHK_PERIOD_RST  = CFG_DATA_W'(0);
  localparam logic [CFG_DATA_W-1:0] STALL_LIMIT_RST = CFG_DATA_W'(3);

  localparam logic [STALE_W-1:0] STALE_MAX = '1;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] chk_period;
    logic [CFG_DATA_W-1:0] stall_limit;
  } cfg_t;

endpackage

// ===== sv/heartbeat_stall_monitor.sv =====
// Heartbeat stall monitor.
// Input stream: one transaction per dispatch event; in_tdata carries one
// 64-bit heartbeat count per monitored worker, channel 0 in the low bits.
// Output stream: exactly one transaction per input transaction, in order,
// carrying checked, the per-channel stall mask, the one-shot report flag
// and the running dispatch number (starting at 1, wrapping at 2^64).
// Config channel: cfg_addr 0 = check period (0 selects DEFAULT_INTERVAL),
// cfg_addr 1 = stall_limit; other indexes are dropped. cfg_ready is always
// high; write only while the stream is idle.
// Path: input acceptance into the input register, then the check logic
// into the output register, which drives out_tvalid.
// Throughput: 1 transaction per cycle while out_tready stays high; the limit
// is the combinational update of the per-channel stale counters and snapshot compare.
// Reset (rst_n low, synchronous): both stages empty, counters, phase,
// baseline and report latch cleared, config back to interval 0 / limit 3.
// Receiver stall: the output register holds its transaction; the input
// register, if empty, still takes one more transaction, after which in_tready drops.
module heartbeat_stall_monitor #(
  parameter int CHANNELS         = 3,
  parameter int DEFAULT_INTERVAL = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // [CHANNELS*64-1:0]: beat_count per channel, channel 0 lowest
  input  logic [CHANNELS*hsm_pkg::BEAT_W-1:0] in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // checked [0], stall_mask [CHANNELS:1], report [CHANNELS+1],
  // dispatch_index [CHANNELS+65:CHANNELS+2], zero pad to bytes
  output logic [((CHANNELS+66+7)/8)*8-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hsm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [hsm_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hsm_pkg::*;

  localparam int IN_W   = CHANNELS*BEAT_W;
  localparam int OUT_W  = ((CHANNELS+66+7)/8)*8;
  localparam int MASK_L = 1;
  localparam int REP_B  = CHANNELS+1;
  localparam int IDX_L  = CHANNELS+2;

  cfg_t cfg_r;

  logic [IN_W-1:0]  in_data_r;
  logic             in_valid_r;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             out_valid_r;
  logic             advance, fire;

  logic                checked;
  logic [CHANNELS-1:0] stall_mask;
  logic                report;
  logic [BEAT_W-1:0]   dispatch_index;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.chk_period  <= CHK_PERIOD_RST;
      cfg_r.stall_limit <= STALL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_addr)
        REG_CHK_PERIOD:  cfg_r.chk_period  <= cfg_data;
        REG_STALL_LIMIT: cfg_r.stall_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register frees up when empty or being taken
  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_data_r <= in_tdata;
    end
  end

  hsm_core #(
    .CHANNELS        (CHANNELS),
    .DEFAULT_INTERVAL(DEFAULT_INTERVAL)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .beats         (in_data_r),
    .cfg           (cfg_r),
    .checked       (checked),
    .stall_mask    (stall_mask),
    .report        (report),
    .dispatch_index(dispatch_index)
  );

  always_comb begin
    out_data_nxt                          = '0;
    out_data_nxt[0]                       = checked;
    out_data_nxt[MASK_L +: CHANNELS]      = stall_mask;
    out_data_nxt[REP_B]                   = report;
    out_data_nxt[IDX_L +: BEAT_W]         = dispatch_index;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_valid_r;

endmodule

// ===== sv/hsm_core.sv =====
module hsm_core #(
  parameter int CHANNELS         = 3,
  parameter int DEFAULT_INTERVAL = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  logic [CHANNELS*hsm_pkg::BEAT_W-1:0]  beats,
  input  hsm_pkg::cfg_t                        cfg,
  output logic                                 checked,
  output logic [CHANNELS-1:0]                  stall_mask,
  output logic                                 report,
  output logic [hsm_pkg::BEAT_W-1:0]           dispatch_index
);
  import hsm_pkg::*;

  localparam logic [CFG_DATA_W-1:0] DEF_IV = CFG_DATA_W'(DEFAULT_INTERVAL);

  logic [BEAT_W-1:0]     dispatch_total_r, dispatch_total_nxt;
  logic [CFG_DATA_W-1:0] phase_r, phase_nxt;
  logic                  base_r, base_nxt;
  logic                  latched_r, latched_nxt;
  logic [BEAT_W-1:0]     last_r   [CHANNELS];
  logic [STALE_W-1:0]    stale_r  [CHANNELS];
  logic [STALE_W-1:0]    stale_nxt[CHANNELS];

  logic [CFG_DATA_W-1:0] interval;
  logic [CFG_DATA_W:0]   phase_inc;
  logic                  is_check;

  assign interval  = (cfg.chk_period == '0) ? DEF_IV : cfg.chk_period;
  assign phase_inc = {1'b0, phase_r} + (CFG_DATA_W+1)'(1);
  assign is_check  = phase_inc >= {1'b0, interval};

  always_comb begin
    dispatch_total_nxt = dispatch_total_r + BEAT_W'(1);
    phase_nxt   = is_check ? '0 : phase_inc[CFG_DATA_W-1:0];
    base_nxt    = base_r | is_check;
    checked     = is_check & base_r;
    stall_mask  = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      stale_nxt[i] = stale_r[i];
      if (checked) begin
        if (beats[i*BEAT_W +: BEAT_W] > last_r[i]) begin
          stale_nxt[i] = '0;
        end else if (stale_r[i] != STALE_MAX) begin
          stale_nxt[i] = stale_r[i] + STALE_W'(1);
        end
        stall_mask[i] = stale_nxt[i] >= cfg.stall_limit;
      end
    end
    // one-shot report, re-armed by a clean check
    report      = checked & (|stall_mask) & ~latched_r;
    latched_nxt = latched_r;
    if (checked) begin
      latched_nxt = |stall_mask;
    end
    dispatch_index = dispatch_total_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dispatch_total_r <= '0;
      phase_r          <= '0;
      base_r           <= 1'b0;
      latched_r        <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        stale_r[i] <= '0;
      end
    end else if (fire) begin
      dispatch_total_r <= dispatch_total_nxt;
      phase_r          <= phase_nxt;
      base_r           <= base_nxt;
      latched_r        <= latched_nxt;
      for (int i = 0; i < CHANNELS; i++) begin
        stale_r[i] <= stale_nxt[i];
      end
    end
  end

  // snapshot is only read once a baseline exists
  always_ff @(posedge clk) begin
    if (fire && is_check) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_r[i] <= beats[i*BEAT_W +: BEAT_W];
      end
    end
  end

endmodule

// ===== sv/hsm_checker.sv =====
module hsm_checker #(
  parameter int CHANNELS = 3
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic [((CHANNELS+66+7)/8)*8-1:0]   out_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready
);

  logic                checked;
  logic [CHANNELS-1:0] mask;
  logic                report;

  assign checked = out_tdata[0];
  assign mask    = out_tdata[CHANNELS:1];
  assign report  = out_tdata[CHANNELS+1];

  // held transaction stays put under backpressure
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_report_needs_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && report |-> checked && (mask != '0))
    else $error("report without a stalled channel");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !checked |-> (mask == '0) && !report)
    else $error("stall info on a non-check dispatch");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind heartbeat_stall_monitor hsm_checker #(.CHANNELS(CHANNELS)) u_hsm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tdata (out_tdata),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready)
);
